// ===== rtl/rmlt_pkg.sv =====
// ============================================================================
// rmlt_pkg: shared types and constants for the recursive mutex lock table
// Function and status codes, the slot record layout, controller states and
// the command and status bundles between the controller and the datapath.
// ============================================================================
package rmlt_pkg;

    // Default number of mutex slots.
    localparam int SLOT_COUNT_DEF = 256;

    // Attribute value that marks a slot as recursive.
    localparam logic [31:0] RECURSIVE_ATTR = 32'h0000_0010;

    // Largest lock depth a slot can hold.
    localparam logic [31:0] DEPTH_MAX = 32'hFFFF_FFFF;

    // Request function codes.
    localparam logic [2:0] FN_CREATE  = 3'd0;
    localparam logic [2:0] FN_DESTROY = 3'd1;
    localparam logic [2:0] FN_LOCK    = 3'd2;
    localparam logic [2:0] FN_TRYLOCK = 3'd3;
    localparam logic [2:0] FN_UNLOCK  = 3'd4;

    // Result status codes.
    localparam logic [2:0] RS_OK          = 3'd0;
    localparam logic [2:0] RS_FAULT       = 3'd1;
    localparam logic [2:0] RS_BUSY        = 3'd2;
    localparam logic [2:0] RS_FULL        = 3'd3;
    localparam logic [2:0] RS_NOT_FOUND   = 3'd4;
    localparam logic [2:0] RS_DEADLOCK    = 3'd5;
    localparam logic [2:0] RS_NOT_OWNED   = 3'd6;
    localparam logic [2:0] RS_WOULD_BLOCK = 3'd7;

    // One slot record as held in the slot memory.
    typedef struct packed {
        logic [31:0] key;
        logic [63:0] owner;
        logic [31:0] depth;
        logic        rec;
    } slot_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic scan_en;
        logic exec_fire;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic trivial;
        logic hit;
        logic scan_done;
        logic out_full;
    } dp_status_t;

endpackage

// ===== rtl/recursive_mutex_lock_table.sv =====
// A request scans the slots from slot 0 upward, one memory read a cycle, until its key
// is found or the whole table is passed, and a create also notes the lowest free slot.
// The execute step then waits until the result register is free and loads the result. The
// next request is taken only after that, so the table holds one request at a time.
// Reset clears the used bits, so the table comes up empty with no clearing pass.
// ============================================================================
// recursive_mutex_lock_table: top level of the recursive mutex lock table
// Joins the request sequencer and the datapath with its slot memory.
// ============================================================================
module recursive_mutex_lock_table #(
    parameter int SLOT_COUNT = rmlt_pkg::SLOT_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  func,
    input  logic [31:0] mutex_key,
    input  logic [63:0] caller_id,
    input  logic [31:0] protocol_word,
    input  logic [31:0] recursive_word,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [2:0]  status,
    output logic [8:0]  slot_number,
    output logic [63:0] owner_id,
    output logic [31:0] recursion_count,
    output logic [31:0] attr_word
);
    import rmlt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t sts;

    // Request sequencer.
    rmlt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Slot table datapath.
    rmlt_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .func            (func),
        .mutex_key       (mutex_key),
        .caller_id       (caller_id),
        .protocol_word   (protocol_word),
        .recursive_word  (recursive_word),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .status          (status),
        .slot_number     (slot_number),
        .owner_id        (owner_id),
        .recursion_count (recursion_count),
        .attr_word       (attr_word)
    );

    // Once a beat is accepted, no further request is taken until it is done.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> req_stall)
        else $error("request taken while one is in flight");

    // Execute never overwrites a result beat that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec_fire |-> !(rsp_valid && rsp_stall))
        else $error("result overwritten while stalled");

    // Every execute step presents a result beat in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec_fire |=> rsp_valid)
        else $error("execute did not produce a result beat");

endmodule

// ===== rtl/rmlt_ctrl.sv =====
// ============================================================================
// rmlt_ctrl: request sequencer for the recursive mutex lock table
// Takes a request, runs the slot scan until a hit, the table end or a trivial
// request, then fires the execute step once the result register is free.
// ============================================================================
module rmlt_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_stall,
    input  rmlt_pkg::dp_status_t   sts,
    output rmlt_pkg::ctrl_cmd_t    cmd
);
    import rmlt_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.trivial || sts.hit || sts.scan_done)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!sts.out_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs. The scan holds still on a hit so the read data stays put.
    always_comb
    begin
        req_stall     = 1'b1;
        cmd.accept    = 1'b0;
        cmd.scan_en   = 1'b0;
        cmd.exec_fire = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_stall  = 1'b0;
                cmd.accept = req_valid;
            end
            S_SCAN:
            begin
                cmd.scan_en = !sts.hit;
            end
            S_EXEC:
            begin
                cmd.exec_fire = !sts.out_full;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/rmlt_dp.sv =====
// ============================================================================
// rmlt_dp: datapath of the recursive mutex lock table
// Holds the request, the slot memory and used bits, the scan pipeline with
// first-free tracking, the execute logic and the result register.
// ============================================================================
module rmlt_dp #(
    parameter int SLOT_COUNT = rmlt_pkg::SLOT_COUNT_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rmlt_pkg::ctrl_cmd_t   cmd,
    output rmlt_pkg::dp_status_t  sts,
    input  logic [2:0]            func,
    input  logic [31:0]           mutex_key,
    input  logic [63:0]           caller_id,
    input  logic [31:0]           protocol_word,
    input  logic [31:0]           recursive_word,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output logic [2:0]            status,
    output logic [8:0]            slot_number,
    output logic [63:0]           owner_id,
    output logic [31:0]           recursion_count,
    output logic [31:0]           attr_word
);
    import rmlt_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    // Request registers.
    logic [2:0]  func_reg;
    logic [31:0] key_reg;
    logic [63:0] tid_reg;
    logic [31:0] proto_reg;
    logic [31:0] rec_reg;

    // Slot storage.
    slot_t                 mem [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] used_reg;
    slot_t                 rd_reg;

    // Scan pipeline.
    logic [CNT_W-1:0] scan_idx_reg;
    logic [IDX_W-1:0] scan_addr;
    logic             scan_active;
    logic             cmp_valid_reg;
    logic             cmp_used_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic             hit;
    logic             trivial;

    // Execute results.
    logic [2:0]       r_status;
    logic [8:0]       r_slot;
    logic [63:0]      r_owner;
    logic [31:0]      r_depth;
    logic [31:0]      r_attr;
    logic             mem_we;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;
    logic             used_we;
    logic             used_val;
    logic [31:0]      dep_inc;
    logic [31:0]      dep_dec;
    logic [31:0]      slot_sum;

    // Result register.
    logic        out_valid_reg;
    logic [2:0]  status_reg;
    logic [8:0]  slot_reg;
    logic [63:0] owner_reg;
    logic [31:0] depth_reg;
    logic [31:0] attr_reg;

    // Capture the request; a thread id of zero stands for thread one.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            func_reg  <= func;
            key_reg   <= mutex_key;
            tid_reg   <= (caller_id == 64'd0) ? 64'd1 : caller_id;
            proto_reg <= protocol_word;
            rec_reg   <= recursive_word;
        end
    end

    assign scan_addr   = scan_idx_reg[IDX_W-1:0];
    assign scan_active = (scan_idx_reg != CNT_W'(SLOT_COUNT));

    // Slot memory: one write port for execute, one registered scan read.
    always_ff @(posedge clk)
    begin
        if (cmd.exec_fire && mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.scan_en && scan_active)
        begin
            rd_reg <= mem[scan_addr];
        end
    end

    // Used bits, cleared at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (cmd.exec_fire && used_we)
        begin
            used_reg[wr_addr] <= used_val;
        end
    end

    // Scan control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            scan_idx_reg   <= '0;
            cmp_valid_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else if (cmd.scan_en)
        begin
            if (scan_active)
            begin
                scan_idx_reg  <= scan_idx_reg + CNT_W'(1);
                cmp_valid_reg <= 1'b1;
            end
            else
            begin
                cmp_valid_reg <= 1'b0;
            end
            if (cmp_valid_reg && !cmp_used_reg && !free_found_reg)
            begin
                free_found_reg <= 1'b1;
            end
        end
    end

    // Scan payload: slot index in the compare stage and first free slot.
    always_ff @(posedge clk)
    begin
        if (cmd.scan_en)
        begin
            if (scan_active)
            begin
                cmp_idx_reg  <= scan_addr;
                cmp_used_reg <= used_reg[scan_addr];
            end
            if (cmp_valid_reg && !cmp_used_reg && !free_found_reg)
            begin
                free_idx_reg <= cmp_idx_reg;
            end
        end
    end

    // Compare stage and request classification.
    assign hit = cmp_valid_reg && cmp_used_reg && (rd_reg.key == key_reg);
    assign trivial = !(func_reg inside {[FN_CREATE:FN_UNLOCK]})
                     || (func_reg == FN_CREATE && key_reg == 32'd0);

    assign sts.trivial   = trivial;
    assign sts.hit       = hit;
    assign sts.scan_done = !cmp_valid_reg && !scan_active;
    assign sts.out_full  = out_valid_reg && rsp_stall;

    assign dep_inc  = rd_reg.depth + 32'd1;
    assign dep_dec  = rd_reg.depth - 32'd1;
    assign slot_sum = 32'(free_idx_reg) + 32'd1;

    // Execute: work out the result and the slot update.
    always_comb
    begin
        r_status = RS_FAULT;
        r_slot   = '0;
        r_owner  = '0;
        r_depth  = '0;
        r_attr   = '0;
        mem_we   = 1'b0;
        wr_addr  = cmp_idx_reg;
        wr_data  = rd_reg;
        used_we  = 1'b0;
        used_val = 1'b0;
        if (trivial)
        begin
            r_status = RS_FAULT;
        end
        else if (func_reg == FN_CREATE)
        begin
            if (hit)
            begin
                r_status = RS_BUSY;
                r_owner  = rd_reg.owner;
                r_depth  = rd_reg.depth;
            end
            else if (free_found_reg)
            begin
                r_status      = RS_OK;
                r_slot        = slot_sum[8:0];
                r_attr        = proto_reg | rec_reg;
                mem_we        = 1'b1;
                wr_addr       = free_idx_reg;
                wr_data.key   = key_reg;
                wr_data.owner = '0;
                wr_data.depth = '0;
                wr_data.rec   = (rec_reg == RECURSIVE_ATTR);
                used_we       = 1'b1;
                used_val      = 1'b1;
            end
            else
            begin
                r_status = RS_FULL;
            end
        end
        else if (!hit)
        begin
            r_status = RS_NOT_FOUND;
        end
        else
        begin
            r_owner = rd_reg.owner;
            r_depth = rd_reg.depth;
            case (func_reg)
                FN_DESTROY:
                begin
                    if (rd_reg.owner != 64'd0)
                    begin
                        r_status = RS_BUSY;
                    end
                    else
                    begin
                        r_status = RS_OK;
                        r_depth  = '0;
                        used_we  = 1'b1;
                        used_val = 1'b0;
                    end
                end
                FN_LOCK, FN_TRYLOCK:
                begin
                    if (rd_reg.owner == tid_reg && !rd_reg.rec)
                    begin
                        r_status = RS_DEADLOCK;
                    end
                    else if (rd_reg.owner != 64'd0 && rd_reg.owner != tid_reg)
                    begin
                        r_status = (func_reg == FN_LOCK) ? RS_WOULD_BLOCK : RS_BUSY;
                    end
                    else if (rd_reg.depth == DEPTH_MAX)
                    begin
                        r_status = RS_BUSY;
                    end
                    else
                    begin
                        r_status      = RS_OK;
                        r_owner       = tid_reg;
                        r_depth       = dep_inc;
                        mem_we        = 1'b1;
                        wr_data.owner = tid_reg;
                        wr_data.depth = dep_inc;
                    end
                end
                FN_UNLOCK:
                begin
                    if (rd_reg.owner != tid_reg || rd_reg.depth == 32'd0)
                    begin
                        r_status = RS_NOT_OWNED;
                    end
                    else
                    begin
                        r_status      = RS_OK;
                        r_depth       = dep_dec;
                        r_owner       = (dep_dec == 32'd0) ? 64'd0 : rd_reg.owner;
                        mem_we        = 1'b1;
                        wr_data.depth = dep_dec;
                        wr_data.owner = (dep_dec == 32'd0) ? 64'd0 : rd_reg.owner;
                    end
                end
                default:
                begin
                    r_status = RS_FAULT;
                end
            endcase
        end
    end

    // Result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.exec_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.exec_fire)
        begin
            status_reg <= r_status;
            slot_reg   <= r_slot;
            owner_reg  <= r_owner;
            depth_reg  <= r_depth;
            attr_reg   <= r_attr;
        end
    end

    assign rsp_valid       = out_valid_reg;
    assign status          = status_reg;
    assign slot_number     = slot_reg;
    assign owner_id        = owner_reg;
    assign recursion_count = depth_reg;
    assign attr_word       = attr_reg;

    // The scan index never runs past the end of the table.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scan_idx_reg <= CNT_W'(SLOT_COUNT))
        else $error("scan index ran past the table");

    // A create only claims a slot that is really free.
    a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec_fire && mem_we && func_reg == FN_CREATE |-> !used_reg[free_idx_reg])
        else $error("create claimed a used slot");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_top: self-checking bench for the recursive mutex lock table
// Feeds create, destroy, lock, trylock and unlock beats to the table, keeps a
// shadow copy of every slot to work out each answer, and compares every result
// beat field by field. Both sides idle and stall at random in the first two of three phases.
// ============================================================================
module tb_top;
    import rmlt_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;

    // One request beat as the table takes it.
    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] key;
        logic [63:0] tid;
        logic [31:0] proto;
        logic [31:0] rec;
    } mutex_req_t;

    // One answer beat as the table returns it.
    typedef struct packed {
        logic [2:0]  status;
        logic [8:0]  slot_num;
        logic [63:0] owner;
        logic [31:0] depth;
        logic [31:0] attr;
    } lock_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    logic [2:0]  func = FN_CREATE;
    logic [31:0] mutex_key = 32'd0;
    logic [63:0] caller_id = 64'd0;
    logic [31:0] protocol_word = 32'd0;
    logic [31:0] recursive_word = 32'd0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [2:0]  status;
    logic [8:0]  slot_number;
    logic [63:0] owner_id;
    logic [31:0] recursion_count;
    logic [31:0] attr_word;

    // Shadow copy of the slot table.
    logic        tbl_used  [SLOTS];
    logic [31:0] tbl_key   [SLOTS];
    logic [63:0] tbl_owner [SLOTS];
    logic [31:0] tbl_depth [SLOTS];
    logic        tbl_rec   [SLOTS];

    mutex_req_t   request_backlog[$];
    lock_result_t expected_answers[$];
    logic [31:0]  key_pool [8];
    logic [63:0]  tid_pool [4];

    int   total_requests = 0;
    int   req_count = 0;
    int   rsp_count = 0;
    int   fail_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic req_taken = 1'b0;
    logic hold_rsp = 1'b0;

    recursive_mutex_lock_table #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .func(func),
        .mutex_key(mutex_key),
        .caller_id(caller_id),
        .protocol_word(protocol_word),
        .recursive_word(recursive_word),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .status(status),
        .slot_number(slot_number),
        .owner_id(owner_id),
        .recursion_count(recursion_count),
        .attr_word(attr_word)
    );

    // Apply one request to the shadow table and return the answer it gives.
    function automatic lock_result_t predict_mutex_op(mutex_req_t r);
        lock_result_t res;
        logic [63:0]  tid;
        int           s;
        res = '0;
        res.status = RS_FAULT;
        tid = (r.tid == 64'd0) ? 64'd1 : r.tid;
        s = -1;
        // Keys are unique among used slots, so the first hit is the only one.
        if (r.op <= FN_UNLOCK && r.key != 32'd0)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (s < 0 && tbl_used[i] && tbl_key[i] == r.key)
                    s = i;
            end
        end
        if (r.op == FN_CREATE)
        begin
            if (r.key == 32'd0)
                res.status = RS_FAULT;
            else if (s >= 0)
                res.status = RS_BUSY;
            else
            begin
                // Claim the lowest free slot, if any.
                res.status = RS_FULL;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (s < 0 && !tbl_used[i])
                        s = i;
                end
                if (s >= 0)
                begin
                    tbl_used[s] = 1'b1;
                    tbl_key[s] = r.key;
                    tbl_owner[s] = 64'd0;
                    tbl_depth[s] = 32'd0;
                    tbl_rec[s] = (r.rec == RECURSIVE_ATTR);
                    res.status = RS_OK;
                    res.slot_num = 9'(s + 1);
                    res.attr = r.proto | r.rec;
                end
            end
        end
        else if (r.op <= FN_UNLOCK && s < 0)
            res.status = RS_NOT_FOUND;
        else if (r.op == FN_DESTROY)
        begin
            if (tbl_owner[s] != 64'd0)
                res.status = RS_BUSY;
            else
            begin
                tbl_used[s] = 1'b0;
                tbl_key[s] = 32'd0;
                tbl_depth[s] = 32'd0;
                res.status = RS_OK;
            end
        end
        else if (r.op == FN_LOCK || r.op == FN_TRYLOCK)
        begin
            if (tbl_owner[s] == tid && !tbl_rec[s])
                res.status = RS_DEADLOCK;
            else if (tbl_owner[s] != 64'd0 && tbl_owner[s] != tid)
                res.status = (r.op == FN_LOCK) ? RS_WOULD_BLOCK : RS_BUSY;
            else if (tbl_depth[s] == DEPTH_MAX)
                res.status = RS_BUSY;
            else
            begin
                tbl_owner[s] = tid;
                tbl_depth[s] = tbl_depth[s] + 32'd1;
                res.status = RS_OK;
            end
        end
        else if (r.op == FN_UNLOCK)
        begin
            if (tbl_owner[s] != tid || tbl_depth[s] == 32'd0)
                res.status = RS_NOT_OWNED;
            else
            begin
                tbl_depth[s] = tbl_depth[s] - 32'd1;
                if (tbl_depth[s] == 32'd0)
                    tbl_owner[s] = 64'd0;
                res.status = RS_OK;
            end
        end
        // Answers that found a slot report its owner and depth after the request.
        if (s >= 0)
        begin
            res.owner = tbl_owner[s];
            res.depth = tbl_depth[s];
        end
        return res;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic push_request(logic [2:0] op, logic [31:0] key, logic [63:0] tid,
                                logic [31:0] proto, logic [31:0] rec);
        request_backlog.push_back('{op, key, tid, proto, rec});
    endtask

    // Mostly pool keys and pool threads so that slots get created, locked
    // and released again; a few beats carry odd keys or unknown codes.
    task automatic push_random_request();
        int          pick;
        logic [2:0]  op;
        logic [31:0] key;
        pick = $urandom_range(99);
        if (pick < 15)
            op = FN_CREATE;
        else if (pick < 25)
            op = FN_DESTROY;
        else if (pick < 50)
            op = FN_LOCK;
        else if (pick < 70)
            op = FN_TRYLOCK;
        else if (pick < 95)
            op = FN_UNLOCK;
        else
            op = 3'($urandom_range(7, FN_UNLOCK + 1));
        if ($urandom_range(19) == 0)
            key = $urandom_range(1) ? 32'd0 : 32'($urandom());
        else
            key = key_pool[$urandom_range(7)];
        push_request(op, key, tid_pool[$urandom_range(3)], $urandom(),
                     $urandom_range(1) ? RECURSIVE_ATTR : 32'($urandom()));
    endtask

    // Clock.
    initial
    begin
        forever #1 clk = ~clk;
    end

    // Reset is held from the start and released on a falling edge.
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Request driver: a new beat goes out once the last one was taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            send_idle_pct = (req_count < total_requests / 3) ? 16 :
                            (req_count < 2 * total_requests / 3) ? 49 : 0;
            if (!req_valid || req_taken)
            begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    func           <= request_backlog[0].op;
                    mutex_key      <= request_backlog[0].key;
                    caller_id      <= request_backlog[0].tid;
                    protocol_word  <= request_backlog[0].proto;
                    recursive_word <= request_backlog[0].rec;
                    void'(request_backlog.pop_front());
                    req_valid <= 1'b1;
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus the long hold-off when asked.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            recv_stall_pct = (rsp_count < total_requests / 3) ? 49 :
                             (rsp_count < 2 * total_requests / 3) ? 16 : 0;
            rsp_stall <= hold_rsp || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: checks result beats and predicts each accepted request beat.
    always @(posedge clk)
    begin
        lock_result_t want;
        if (rst_n)
        begin
            req_taken <= req_valid && !req_stall;
            if (rsp_valid && !rsp_stall)
            begin
                rsp_count++;
                if (expected_answers.size() == 0)
                begin
                    $error("result beat with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_answers.pop_front();
                    check_field("status", 64'(want.status), 64'(status));
                    check_field("slot_number", 64'(want.slot_num), 64'(slot_number));
                    check_field("owner_id", want.owner, owner_id);
                    check_field("recursion_count", 64'(want.depth), 64'(recursion_count));
                    check_field("attr_word", 64'(want.attr), 64'(attr_word));
                end
            end
            if (req_valid && !req_stall)
            begin
                req_count++;
                expected_answers.push_back(predict_mutex_op(
                    '{func, mutex_key, caller_id, protocol_word, recursive_word}));
            end
        end
    end

    // Hold the result side off long enough that the table backs up its input.
    initial
    begin
        while (rsp_count < 40)
            @(posedge clk);
        hold_rsp = 1'b1;
        repeat (800) @(posedge clk);
        hold_rsp = 1'b0;
    end

    // Overall time limit.
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // Stimulus and end of run.
    initial
    begin
        logic [31:0] key_a;
        logic [31:0] key_b;
        logic [63:0] tid_max;
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_used[i] = 1'b0;
            tbl_key[i] = 32'd0;
            tbl_owner[i] = 64'd0;
            tbl_depth[i] = 32'd0;
            tbl_rec[i] = 1'b0;
        end
        key_a = 32'h0000_1000;
        key_b = 32'hA5A5_0004;
        tid_max = '1;
        key_pool[0] = 32'hFFFF_FFFF;
        for (int i = 1; i < 8; i++)
            key_pool[i] = $urandom();
        tid_pool[0] = 64'd0;
        tid_pool[1] = 64'd1;
        tid_pool[2] = {32'($urandom()), 32'($urandom())};
        tid_pool[3] = tid_max;

        // Create: zero key, recursive slot, duplicate, near-miss attribute.
        push_request(FN_CREATE, 32'd0, 64'd1, 32'd0, 32'd0);
        push_request(FN_CREATE, key_a, 64'd0, 32'hFFFF_FFEF, RECURSIVE_ATTR);
        push_request(FN_CREATE, key_a, 64'd0, 32'd0, 32'd0);
        push_request(FN_CREATE, key_b, 64'd0, 32'd0, 32'h0000_0011);
        // Recursive slot: thread 0 acts as thread 1, others are turned away.
        push_request(FN_LOCK, key_a, 64'd0, 32'd0, 32'd0);
        push_request(FN_TRYLOCK, key_a, 64'd1, 32'd0, 32'd0);
        push_request(FN_LOCK, key_a, 64'd2, 32'd0, 32'd0);
        push_request(FN_TRYLOCK, key_a, 64'd2, 32'd0, 32'd0);
        push_request(FN_DESTROY, key_a, 64'd1, 32'd0, 32'd0);
        push_request(FN_UNLOCK, key_a, 64'd2, 32'd0, 32'd0);
        push_request(FN_UNLOCK, key_a, 64'd0, 32'd0, 32'd0);
        push_request(FN_UNLOCK, key_a, 64'd1, 32'd0, 32'd0);
        push_request(FN_UNLOCK, key_a, 64'd1, 32'd0, 32'd0);
        // Plain slot: relock by the owner deadlocks.
        push_request(FN_LOCK, key_b, tid_max, 32'd0, 32'd0);
        push_request(FN_LOCK, key_b, tid_max, 32'd0, 32'd0);
        push_request(FN_TRYLOCK, key_b, tid_max, 32'd0, 32'd0);
        push_request(FN_UNLOCK, key_b, tid_max, 32'd0, 32'd0);
        push_request(FN_DESTROY, key_b, tid_max, 32'd0, 32'd0);
        push_request(FN_LOCK, key_b, tid_max, 32'd0, 32'd0);
        push_request(FN_UNLOCK, 32'hFFFF_FFFF, 64'd0, 32'd0, 32'd0);
        // The freed slot is the lowest free one again.
        push_request(FN_CREATE, 32'hFFFF_FFFF, 64'd0, 32'd0, 32'hFFFF_FFFF);
        for (int u = FN_UNLOCK + 1; u < 8; u++)
            push_request(3'(u), key_a, 64'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_request(FN_DESTROY, key_a, 64'd0, 32'd0, 32'd0);
        push_request(FN_DESTROY, 32'hFFFF_FFFF, 64'd0, 32'd0, 32'd0);

        // Random traffic over a small key pool.
        for (int n = 0; n < 220; n++)
            push_random_request();
        // Fill the table past capacity, then keep working on a full table.
        for (int n = 0; n < SLOTS + 4; n++)
            push_request(FN_CREATE, 32'($urandom()) | 32'd1, tid_pool[$urandom_range(3)],
                         $urandom(), $urandom_range(1) ? RECURSIVE_ATTR : 32'($urandom()));
        for (int n = 0; n < 20; n++)
            push_random_request();
        total_requests = request_backlog.size();

        while (req_count < total_requests)
            @(posedge clk);
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (SLOTS + 8) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
